// ===== design/rrts_pkg.sv =====
`timescale 1ns / 1ps

package rrts_pkg;

    localparam int ID_W       = 8;
    localparam int SVC_W      = 16;
    localparam int SLICE_W    = 16;
    localparam int OUT_TIME_W = 32;
    localparam int S_DATA_W   = ID_W + SVC_W;
    localparam int M_DATA_W   = ID_W + 2 * OUT_TIME_W;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd4;

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_DROP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_EMIT = 3'b100
    } rrts_state_t;

    typedef struct packed {
        logic arrive;
        logic exec;
        logic load_out;
    } rrts_cmd_t;

    typedef struct packed {
        logic drop;
        logic finish;
        logic out_free;
    } rrts_sts_t;

endpackage

// ===== design/rrts_ram.sv =====
`timescale 1ns / 1ps

module rrts_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rrts_ctrl.sv =====
`timescale 1ns / 1ps

module rrts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    input  logic               s_axis_tuser,
    output logic               s_axis_tready,
    input  rrts_pkg::rrts_sts_t sts,
    output rrts_pkg::rrts_cmd_t cmd
);

    import rrts_pkg::*;

    rrts_state_t state_reg;
    rrts_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser == MODE_TICK)
                    begin
                        // The head entry is read at this edge and used next cycle.
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        cmd.arrive = 1'b1;
                        if (sts.drop)
                        begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.finish ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rrts_dp.sv =====
`timescale 1ns / 1ps

module rrts_dp #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [rrts_pkg::SLICE_W-1:0]  cfg_data,
    input  logic [rrts_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rrts_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tuser,
    input  rrts_pkg::rrts_cmd_t           cmd,
    output rrts_pkg::rrts_sts_t           sts
);

    import rrts_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_W + SVC_W + TIME_BITS;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    logic [SLICE_W-1:0]   time_slice_reg;
    logic [TIME_BITS-1:0] time_now_reg;
    logic [PTR_W-1:0]     head_reg;
    logic [PTR_W-1:0]     tail_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 run_valid_reg;
    logic [ID_W-1:0]      run_id_reg;
    logic [SVC_W-1:0]     run_rem_reg;
    logic [TIME_BITS-1:0] run_arr_reg;
    logic [SLICE_W-1:0]   slice_used_reg;

    logic                  res_status_reg;
    logic [ID_W-1:0]       res_id_reg;
    logic [OUT_TIME_W-1:0] res_done_reg;
    logic [OUT_TIME_W-1:0] res_turn_reg;

    logic                m_valid_reg;
    logic                m_user_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [ID_W-1:0]      in_id;
    logic [SVC_W-1:0]     in_svc;
    logic                 drop;

    logic [ENTRY_W-1:0]   rd_entry;
    logic [ID_W-1:0]      rd_id;
    logic [SVC_W-1:0]     rd_rem;
    logic [TIME_BITS-1:0] rd_arr;

    logic                 disp;
    logic                 cur_valid;
    logic [ID_W-1:0]      cur_id;
    logic [SVC_W-1:0]     cur_rem;
    logic [TIME_BITS-1:0] cur_arr;
    logic [SLICE_W-1:0]   cur_slice;
    logic [CNT_W-1:0]     cnt_after;
    logic [PTR_W-1:0]     head_after;
    logic [TIME_BITS-1:0] time_inc;
    logic [SVC_W-1:0]     rem_dec;
    logic [SLICE_W-1:0]   slice_inc;
    logic                 finish;
    logic                 preempt;

    logic                 arr_push;
    logic                 ram_we;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [PTR_W-1:0]     tail_inc;

    assign in_id  = s_axis_tdata[ID_W-1:0];
    assign in_svc = s_axis_tdata[ID_W +: SVC_W];
    assign drop   = (in_svc == '0) || (count_reg == CNT_FULL);

    // The read port always follows the head; its output is registered, so a tick sees the head entry in the next cycle.
    rrts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (rd_entry)
    );

    assign rd_id  = rd_entry[ID_W-1:0];
    assign rd_rem = rd_entry[ID_W +: SVC_W];
    assign rd_arr = rd_entry[ID_W + SVC_W +: TIME_BITS];

    always_comb
    begin
        disp       = !run_valid_reg && (count_reg != '0);
        cur_valid  = run_valid_reg || disp;
        cur_id     = disp ? rd_id : run_id_reg;
        cur_rem    = disp ? rd_rem : run_rem_reg;
        cur_arr    = disp ? rd_arr : run_arr_reg;
        cur_slice  = disp ? '0 : slice_used_reg;
        cnt_after  = count_reg - CNT_W'(disp);
        head_after = head_reg;
        if (disp)
        begin
            head_after = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        time_inc  = time_now_reg + 1'b1;
        rem_dec   = (cur_rem != '0) ? cur_rem - 1'b1 : cur_rem;
        slice_inc = (cur_slice != '1) ? cur_slice + 1'b1 : cur_slice;
        finish    = cur_valid && (rem_dec == '0);
        // A zero quantum behaves as one because slice_inc is at least one here.
        preempt   = cur_valid && !finish && (slice_inc >= time_slice_reg)
                    && (cnt_after != CNT_FULL);
    end

    assign arr_push  = cmd.arrive && !drop;
    assign ram_we    = arr_push || (cmd.exec && preempt);
    assign ram_wdata = cmd.arrive ? {time_now_reg, in_svc, in_id}
                                  : {cur_arr, rem_dec, cur_id};
    assign tail_inc  = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_slice_reg <= SLICE_RESET;
            time_now_reg   <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            run_valid_reg  <= 1'b0;
            slice_used_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                time_slice_reg <= cfg_data;
            end
            if (ram_we)
            begin
                tail_reg <= tail_inc;
            end
            if (arr_push)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                time_now_reg <= time_inc;
                head_reg     <= head_after;
                count_reg    <= cnt_after + CNT_W'(preempt);
                if (finish || preempt)
                begin
                    run_valid_reg  <= 1'b0;
                    slice_used_reg <= '0;
                end
                else
                begin
                    run_valid_reg  <= cur_valid;
                    slice_used_reg <= cur_valid ? slice_inc : slice_used_reg;
                end
            end
            if (cmd.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && cur_valid)
        begin
            run_id_reg  <= cur_id;
            run_rem_reg <= rem_dec;
            run_arr_reg <= cur_arr;
        end
        if (cmd.arrive)
        begin
            res_status_reg <= STATUS_DROP;
            res_id_reg     <= in_id;
            res_done_reg   <= OUT_TIME_W'(64'(time_now_reg));
            res_turn_reg   <= '0;
        end
        else if (cmd.exec)
        begin
            res_status_reg <= STATUS_DONE;
            res_id_reg     <= cur_id;
            res_done_reg   <= OUT_TIME_W'(64'(time_inc));
            res_turn_reg   <= OUT_TIME_W'(64'(TIME_BITS'(time_inc - cur_arr)));
        end
        if (cmd.load_out)
        begin
            m_user_reg <= res_status_reg;
            m_data_reg <= {res_turn_reg, res_done_reg, res_id_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tdata  = m_data_reg;

    assign sts.drop     = drop;
    assign sts.finish   = finish;
    assign sts.out_free = !m_valid_reg || m_axis_tready;

endmodule

// ===== design/round_robin_time_slice_scheduler_core.sv =====
// Arrival beat: taken in ST_IDLE; a drop report is latched as a result and loaded into the
// output register from ST_EMIT. Tick beat: taken in ST_IDLE while the queue head is read from
// RAM, then ST_EXEC runs the task; a completion report is latched there and loaded from ST_EMIT.
// Up to one arrival per cycle; a tick blocks the input through ST_EXEC. A beat that makes a
// report holds the input through ST_EMIT, and longer while a report waits on m_axis_tready.
// rst_n clears the queue pointers, time, running task and output valid; time_slice resets to 4.
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TIME_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rrts_pkg::SLICE_W-1:0]  cfg_data,   // time_slice
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [rrts_pkg::S_DATA_W-1:0] s_axis_tdata, // task_id, service_time
    input  logic                          s_axis_tuser, // mode
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [rrts_pkg::M_DATA_W-1:0] m_axis_tdata, // task_id_res, done_time, turnaround
    output logic                          m_axis_tuser  // status
);

    import rrts_pkg::*;

    rrts_cmd_t cmd;
    rrts_sts_t sts;

    assign cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    rrts_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== design/rrts_checker.sv =====
`timescale 1ns / 1ps

module rrts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [rrts_pkg::SLICE_W-1:0]  cfg_data,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [rrts_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [rrts_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tuser
);

    import rrts_pkg::*;

    // A report that is not taken holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // A dropped arrival always reports zero turnaround.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == STATUS_DROP) |->
            m_axis_tdata[M_DATA_W-1 -: OUT_TIME_W] == '0)
        else $error("drop report with nonzero turnaround");

    // A tick occupies the block for its execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_TICK) |=> !s_axis_tready)
        else $error("input accepted during tick execution");

    // An arrival with zero service time must be reported, which blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == MODE_ARRIVE)
            && (s_axis_tdata[ID_W +: SVC_W] == '0) |=> !s_axis_tready)
        else $error("zero service time arrival not reported");

    // The configuration port takes every write.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind round_robin_time_slice_scheduler_core rrts_checker u_rrts_checker (.*);

// ===== tb/round_robin_time_slice_scheduler_core_tb.sv =====
`timescale 1ns / 1ps

module round_robin_time_slice_scheduler_core_tb;
    import rrts_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 10;
    localparam int PHASE_ITEMS = 170;

    typedef struct {
        logic        mode;
        logic [7:0]  id;
        logic [15:0] svc;
    } job_t;

    typedef struct {
        logic        status;
        logic [7:0]  id;
        logic [31:0] done;
        logic [31:0] turn;
    } report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [SLICE_W-1:0]  cfg_data = SLICE_RESET;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;   // task_id, service_time
    logic                s_axis_tuser = MODE_ARRIVE;   // mode
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;   // task_id_res, done_time, turnaround
    logic                m_axis_tuser;   // status

    round_robin_time_slice_scheduler_core #(
        .QUEUE_DEPTH(DEPTH),
        .TIME_BITS  (32)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Scheduler shadow state, advanced once per accepted input beat.
    logic [7:0]         ready_id [DEPTH];
    logic [15:0]        ready_left [DEPTH];
    logic [31:0]        ready_stamp [DEPTH];
    logic [3:0]         ready_head = '0;
    logic [3:0]         ready_tail = '0;
    int                 ready_count = 0;
    logic               cpu_busy = 1'b0;
    logic [7:0]         cpu_id = '0;
    logic [15:0]        cpu_left = '0;
    logic [31:0]        cpu_stamp = '0;
    logic [15:0]        cpu_used = '0;
    logic [31:0]        clock_now = '0;
    logic [SLICE_W-1:0] quantum = SLICE_RESET;

    job_t    pending_jobs[$];
    report_t expected_reports[$];
    int      error_count = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      hold_req = 0;
    int      hold_ack = 0;
    int      hold_left = 0;
    int      quiet_cycles = 0;
    logic    s_took = 1'b0;

    task automatic flag_error(input string what);
        if (error_count < 100)
            $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic enqueue_task(input logic [7:0] id, input logic [15:0] left,
                                input logic [31:0] stamp);
        ready_id[ready_tail] = id;
        ready_left[ready_tail] = left;
        ready_stamp[ready_tail] = stamp;
        ready_tail = ready_tail + 4'd1;
        ready_count++;
    endtask

    task automatic schedule_step(input job_t j);
        report_t r;
        r.status = STATUS_DROP;
        r.id = j.id;
        r.done = clock_now;
        r.turn = '0;
        if (j.mode == MODE_ARRIVE) begin
            if (j.svc == 16'd0 || ready_count >= DEPTH) begin
                expected_reports.push_back(r);
            end else begin
                enqueue_task(j.id, j.svc, clock_now);
            end
        end else begin
            if (!cpu_busy && ready_count > 0) begin
                cpu_id = ready_id[ready_head];
                cpu_left = ready_left[ready_head];
                cpu_stamp = ready_stamp[ready_head];
                ready_head = ready_head + 4'd1;
                ready_count--;
                cpu_busy = 1'b1;
                cpu_used = '0;
            end
            clock_now = clock_now + 32'd1;
            if (cpu_busy) begin
                if (cpu_left != 16'd0)
                    cpu_left = cpu_left - 16'd1;
                if (cpu_used != 16'hFFFF)
                    cpu_used = cpu_used + 16'd1;
                if (cpu_left == 16'd0) begin
                    cpu_busy = 1'b0;
                    cpu_used = '0;
                    r.status = STATUS_DONE;
                    r.id = cpu_id;
                    r.done = clock_now;
                    r.turn = clock_now - cpu_stamp;
                    expected_reports.push_back(r);
                end else if (cpu_used >= quantum && ready_count < DEPTH) begin
                    // Quantum spent and there is room: back to the tail.
                    enqueue_task(cpu_id, cpu_left, cpu_stamp);
                    cpu_busy = 1'b0;
                    cpu_used = '0;
                end
            end
        end
    endtask

    always @(posedge clk) begin : monitor
        job_t    job;
        report_t want;
        s_took <= s_axis_tvalid && s_axis_tready;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                quantum = cfg_data;
            if (s_axis_tvalid && s_axis_tready) begin
                job.mode = s_axis_tuser;
                job.id = s_axis_tdata[7:0];
                job.svc = s_axis_tdata[23:8];
                schedule_step(job);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_reports.size() == 0) begin
                    flag_error("report beat with nothing expected");
                end else begin
                    want = expected_reports.pop_front();
                    if (m_axis_tuser !== want.status)
                        flag_error($sformatf("status %0b, expected %0b",
                                             m_axis_tuser, want.status));
                    if (m_axis_tdata[7:0] !== want.id)
                        flag_error($sformatf("task id %0d, expected %0d",
                                             m_axis_tdata[7:0], want.id));
                    if (m_axis_tdata[39:8] !== want.done)
                        flag_error($sformatf("done time %0d, expected %0d",
                                             m_axis_tdata[39:8], want.done));
                    if (m_axis_tdata[71:40] !== want.turn)
                        flag_error($sformatf("turnaround %0d, expected %0d",
                                             m_axis_tdata[71:40], want.turn));
                end
            end
        end
    end

    always @(negedge clk) begin : driver
        job_t j;
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_took) begin
            if (pending_jobs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                j = pending_jobs.pop_front();
                s_axis_tdata <= {j.svc, j.id};
                s_axis_tuser <= j.mode;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver side; a hold request shuts it off for a long stretch.
    always @(negedge clk) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("round_robin_time_slice_scheduler_core verification failed");
            $finish;
        end
    end

    task automatic add_job(input logic mode, input logic [7:0] id, input logic [15:0] svc);
        job_t j;
        j.mode = mode;
        j.id = id;
        j.svc = svc;
        pending_jobs.push_back(j);
    endtask

    task automatic add_random_jobs(input int count);
        int          burst;
        int          roll;
        int          pick;
        logic [15:0] svc;
        burst = 0;
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (burst == 0 && roll < 4)
                burst = 18;
            if (burst == 0 && roll < 75) begin
                // Ticks carry random junk in the ignored fields.
                add_job(MODE_TICK, 8'($urandom), 16'($urandom));
            end else begin
                if (burst > 0)
                    burst--;
                pick = $urandom_range(0, 99);
                if (pick < 6)
                    svc = 16'd0;
                else if (pick < 7)
                    svc = 16'($urandom_range(1, 65535));
                else
                    svc = 16'($urandom_range(1, 6));
                add_job(MODE_ARRIVE, 8'($urandom_range(0, 255)), svc);
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_jobs.size() > 0 || s_axis_tvalid || expected_reports.size() > 0)
            @(posedge clk);
        // Ticks without a report can still be in flight.
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_slice(input logic [SLICE_W-1:0] value);
        @(negedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int slice_plan [6];
        slice_plan = '{1, 2, 12, 3, 65535, 6};
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 29;
        recv_idle_pct = 88;

        // Directed part, run under the reset quantum of 4.
        add_job(MODE_ARRIVE, 8'hFF, 16'h0000);   // zero service time is dropped
        add_job(MODE_TICK, 8'($urandom), 16'($urandom));   // nothing to run
        add_job(MODE_ARRIVE, 8'h00, 16'd1);
        add_job(MODE_TICK, 8'hFF, 16'h0000);     // dispatch and finish on one tick
        add_job(MODE_ARRIVE, 8'h5A, 16'd6);
        add_job(MODE_TICK, 8'h00, 16'hFFFF);
        for (int k = 0; k < DEPTH; k++) begin
            if (k == 0)
                add_job(MODE_ARRIVE, 8'hFF, 16'hFFFF);
            else
                add_job(MODE_ARRIVE, 8'(k * 17), 16'(k % 5 + 1));
        end
        add_job(MODE_ARRIVE, 8'h33, 16'd2);      // queue full
        // The running task overruns its quantum with the queue full, then finishes.
        repeat (6) add_job(MODE_TICK, 8'($urandom), 16'($urandom));
        wait_idle();

        foreach (slice_plan[p]) begin
            send_idle_pct = (p < 2) ? 29 : ((p < 4) ? 88 : 0);
            recv_idle_pct = (p < 2) ? 88 : ((p < 4) ? 29 : 0);
            write_slice(16'(slice_plan[p]));
            add_random_jobs(PHASE_ITEMS);
            if (p == 5)
                hold_req++;
            wait_idle();
        end

        if (expected_reports.size() != 0)
            flag_error($sformatf("%0d reports never arrived", expected_reports.size()));
        if (error_count == 0)
            $display("round_robin_time_slice_scheduler_core verification clean");
        else
            $display("round_robin_time_slice_scheduler_core verification failed");
        $finish;
    end

endmodule
